// ----- rtl/core/length_prefixed_frame_deframer_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Length-prefixed frame deframer assertion macros
// Shared shorthands for the concurrent checks in the deframer RTL. Each macro
// samples on aclk and is disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lpfd_pkg.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Types, codes and constants shared by the deframer parser and top level.
// ---------------------------------------------------------------------------
package lpfd_pkg;

    localparam logic [7:0] MARK0    = 8'h50;  // 'P'
    localparam logic [7:0] MARK1    = 8'h53;  // 'S'
    localparam int         HDR_BYTES = 16;
    localparam int         CNT_W     = $clog2(HDR_BYTES);
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ERROR  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_BODY       = 3'd1,
        KIND_BAD_MARKER = 3'd2,
        KIND_TRUNCATED  = 3'd3,
        KIND_END        = 3'd4
    } kind_t;

    // One stream beat as seen by the parser.
    typedef struct packed {
        logic       stream_end;
        logic [7:0] data_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        kind_t        result_kind;
        logic [15:0]  message_id;
        logic [31:0]  body_length;
        logic [31:0]  time_seconds;
        logic [31:0]  time_nanoseconds;
        logic [7:0]   body_byte;
        logic         frame_last;
    } result_t;

endpackage

// ----- rtl/core/lpfd_parser.sv -----
// ---------------------------------------------------------------------------
// Deframer parse state
// Holds the frame phase, header byte count and collected header fields, and
// forms the result for the beat presented on step.
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_unit_defines.svh"

module lpfd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  lpfd_pkg::item_t  item,
    output logic             res_valid,
    output lpfd_pkg::result_t res
);

    lpfd_pkg::phase_t              phase_reg, phase_next;
    logic [lpfd_pkg::CNT_W-1:0]    header_count_reg, header_count_next;
    logic                          marker_ok_reg, marker_ok_next;
    logic [15:0]                   held_message_id_reg, held_message_id_next;
    logic [31:0]                   held_length_reg, held_length_next;
    logic [31:0]                   held_seconds_reg, held_seconds_next;
    logic [31:0]                   held_nanoseconds_reg, held_nanoseconds_next;
    logic [31:0]                   body_remaining_reg, body_remaining_next;

    logic bad_mark;
    logic res_hit;

    assign bad_mark = ((header_count_reg == lpfd_pkg::CNT_W'(0))
                       && (item.data_byte != lpfd_pkg::MARK0))
                   || ((header_count_reg == lpfd_pkg::CNT_W'(1))
                       && (item.data_byte != lpfd_pkg::MARK1));

    always_comb begin
        phase_next            = phase_reg;
        header_count_next     = header_count_reg;
        marker_ok_next        = marker_ok_reg;
        held_message_id_next  = held_message_id_reg;
        held_length_next      = held_length_reg;
        held_seconds_next     = held_seconds_reg;
        held_nanoseconds_next = held_nanoseconds_reg;
        body_remaining_next   = body_remaining_reg;
        res                   = '0;
        res_hit               = 1'b0;

        if (item.stream_end) begin
            // End of stream always returns the parse state to its reset value.
            phase_next        = lpfd_pkg::PH_HEADER;
            header_count_next = '0;
            marker_ok_next    = 1'b1;
            unique case (phase_reg)
                lpfd_pkg::PH_HEADER: begin
                    res_hit         = 1'b1;
                    res.result_kind = lpfd_pkg::KIND_END;
                end
                lpfd_pkg::PH_BODY: begin
                    res_hit         = 1'b1;
                    res.result_kind = lpfd_pkg::KIND_TRUNCATED;
                end
                default: begin
                    res_hit = 1'b0;
                end
            endcase
        end else begin
            unique case (phase_reg)
                lpfd_pkg::PH_HEADER: begin
                    // Marker bytes that match are shifted into the id like any other.
                    if (bad_mark) begin
                        marker_ok_next = 1'b0;
                    end else begin
                        unique case (header_count_reg[3:2])
                            2'd0: held_message_id_next =
                                {held_message_id_reg[7:0], item.data_byte};
                            2'd1: held_length_next =
                                {held_length_reg[23:0], item.data_byte};
                            2'd2: held_seconds_next =
                                {held_seconds_reg[23:0], item.data_byte};
                            default: held_nanoseconds_next =
                                {held_nanoseconds_reg[23:0], item.data_byte};
                        endcase
                    end

                    if (header_count_reg != lpfd_pkg::HDR_LAST) begin
                        header_count_next = header_count_reg + lpfd_pkg::CNT_W'(1);
                    end else begin
                        header_count_next = '0;
                        res_hit           = 1'b1;
                        if (!marker_ok_next) begin
                            marker_ok_next  = 1'b1;
                            phase_next      = lpfd_pkg::PH_ERROR;
                            res.result_kind = lpfd_pkg::KIND_BAD_MARKER;
                        end else begin
                            res.result_kind      = lpfd_pkg::KIND_HEADER;
                            res.message_id       = held_message_id_next;
                            res.body_length      = held_length_next;
                            res.time_seconds     = held_seconds_next;
                            res.time_nanoseconds = held_nanoseconds_next;
                            res.frame_last       = (held_length_next == 32'd0);
                            body_remaining_next  = held_length_next;
                            phase_next = (held_length_next == 32'd0)
                                       ? lpfd_pkg::PH_HEADER : lpfd_pkg::PH_BODY;
                        end
                    end
                end
                lpfd_pkg::PH_BODY: begin
                    res_hit             = 1'b1;
                    res.result_kind     = lpfd_pkg::KIND_BODY;
                    res.body_byte       = item.data_byte;
                    body_remaining_next = body_remaining_reg - 32'd1;
                    if (body_remaining_reg == 32'd1) begin
                        res.frame_last = 1'b1;
                        phase_next     = lpfd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    // Error phase, and the unused code: drop the byte.
                    res_hit = 1'b0;
                end
            endcase
        end
    end

    assign res_valid = step && res_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= lpfd_pkg::PH_HEADER;
            header_count_reg <= '0;
            marker_ok_reg    <= 1'b1;
        end else if (step) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            marker_ok_reg    <= marker_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_message_id_reg  <= held_message_id_next;
            held_length_reg      <= held_length_next;
            held_seconds_reg     <= held_seconds_next;
            held_nanoseconds_reg <= held_nanoseconds_next;
            body_remaining_reg   <= body_remaining_next;
        end
    end

    `LPFD_ASSERT_IMP(a_body_count_live, phase_reg == lpfd_pkg::PH_BODY,
        body_remaining_reg != 32'd0, "body phase with no bytes remaining")
    `LPFD_ASSERT_IMP(a_count_in_header, header_count_reg != '0,
        phase_reg == lpfd_pkg::PH_HEADER, "header count running outside header phase")
    `LPFD_ASSERT_NXT(a_last_body_closes,
        res_valid && res.frame_last && (res.result_kind == lpfd_pkg::KIND_BODY),
        phase_reg == lpfd_pkg::PH_HEADER, "final body byte did not close the frame")

endmodule

// ----- rtl/core/length_prefixed_frame_deframer_unit.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed frame deframer
// Splits a byte stream into 16-byte headers and pass-through body bytes.
// ---------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  --------+-----------+----------------------------------------------------
//  s_axis  | in        | one stream byte, or an end-of-stream marker
//  m_axis  | out       | header, body byte, error or end-of-stream result
//
// One beat is accepted per clock when the output side keeps up; the parser
// sits between a one-beat input register and a one-beat result register.
// An accepted beat passes through the input register, then its result through the result register.
// A stall on m_axis holds the result register; the input register still
// takes one more beat, after which s_axis_tready drops until the stall ends.
// aresetn is synchronous and clears the valid flags of both registers and the parse state.
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_unit_defines.svh"

module length_prefixed_frame_deframer_unit (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] stream_end

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] message_id, [47:16] body_length, [79:48] time_seconds,
    // [111:80] time_nanoseconds, [119:112] body_byte
    output logic [119:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] result_kind
    output logic         m_axis_tlast
);

    logic              in_valid_reg;
    lpfd_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    lpfd_pkg::result_t out_res_reg;

    logic              advance;
    logic              s_accept;
    logic              res_valid;
    lpfd_pkg::result_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    lpfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            // A beat that causes no result still frees the result slot.
            if (advance) begin
                out_valid_reg <= res_valid;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte  <= s_axis_tdata;
            in_item_reg.stream_end <= s_axis_tuser;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.body_byte, out_res_reg.time_nanoseconds,
                            out_res_reg.time_seconds, out_res_reg.body_length,
                            out_res_reg.message_id};
    assign m_axis_tuser  = out_res_reg.result_kind;
    assign m_axis_tlast  = out_res_reg.frame_last;

    `LPFD_ASSERT_IMP(a_last_kind, m_axis_tvalid && m_axis_tlast,
        (m_axis_tuser == lpfd_pkg::KIND_HEADER) || (m_axis_tuser == lpfd_pkg::KIND_BODY),
        "last flag on a result that is neither header nor body byte")
    `LPFD_ASSERT_IMP(a_hdr_fields_clear,
        m_axis_tvalid && (m_axis_tuser != lpfd_pkg::KIND_HEADER),
        m_axis_tdata[111:0] == 112'd0, "header fields set on a non-header result")
    `LPFD_ASSERT_NXT(a_input_not_dropped, in_valid_reg && !advance,
        in_valid_reg, "held input beat lost without being parsed")

endmodule
